FILE: hdl/utf8sv_pkg.sv
package utf8sv_pkg;

  localparam int unsigned COUNT_W = 17;
  localparam int unsigned ACC_W   = 21;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [0:0] REG_MAX_BYTES = 1'b0;
  localparam logic [CFG_W-1:0] MAX_BYTES_RESET = 16'hFFFF;

  localparam logic [7:0] ASCII_MAX   = 8'h7F;
  localparam logic [7:0] LEAD2_MASK  = 8'hE0;
  localparam logic [7:0] LEAD2_TAG   = 8'hC0;
  localparam logic [7:0] LEAD3_MASK  = 8'hF0;
  localparam logic [7:0] LEAD3_TAG   = 8'hE0;
  localparam logic [7:0] LEAD4_MASK  = 8'hF8;
  localparam logic [7:0] LEAD4_TAG   = 8'hF0;
  localparam logic [7:0] CONT_MASK   = 8'hC0;
  localparam logic [7:0] CONT_TAG    = 8'h80;

  localparam logic [ACC_W-1:0] MIN_CP2   = 21'h00080;
  localparam logic [ACC_W-1:0] MIN_CP3   = 21'h00800;
  localparam logic [ACC_W-1:0] MIN_CP4   = 21'h10000;
  localparam logic [ACC_W-1:0] MAX_CP    = 21'h10FFFF;
  localparam logic [ACC_W-1:0] SURR_LOW  = 21'h0D800;
  localparam logic [ACC_W-1:0] SURR_HIGH = 21'h0DFFF;

  localparam logic [2:0] SEQ_LEN1 = 3'd1;
  localparam logic [2:0] SEQ_LEN2 = 3'd2;
  localparam logic [2:0] SEQ_LEN3 = 3'd3;
  localparam logic [2:0] SEQ_LEN4 = 3'd4;

  typedef enum logic [1:0] {
    VERDICT_VALID    = 2'd0,
    VERDICT_TOO_LONG = 2'd1,
    VERDICT_NULL     = 2'd2,
    VERDICT_BAD_UTF8 = 2'd3
  } verdict_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [1:0]         pend;
    logic [2:0]         seq_len;
    logic [ACC_W-1:0]   acc;
    logic               null_seen;
    logic               bad;
  } str_state_t;

  typedef struct packed {
    str_state_t         state_next;
    verdict_t           verdict;
    logic [COUNT_W-1:0] length;
  } dec_result_t;

endpackage

FILE: hdl/utf8sv_decode.sv
module utf8sv_decode
  import utf8sv_pkg::*;
(
  input  str_state_t     cur,
  input  logic [7:0]     byte_in,
  input  logic           last_byte,
  input  logic [CFG_W-1:0] limit,
  output dec_result_t    res
);

  str_state_t         nxt;
  logic [COUNT_W-1:0] count_cap;
  logic [ACC_W-1:0]   acc_shift;
  logic [1:0]         pend_dec;
  logic               cp_reject;
  logic               fin_bad;

  always_comb begin
    nxt       = cur;
    count_cap = {1'b0, limit} + 17'd1;
    acc_shift = {cur.acc[ACC_W-7:0], byte_in[5:0]};
    pend_dec  = cur.pend - 2'd1;
    cp_reject = ((cur.seq_len == SEQ_LEN2) && (acc_shift < MIN_CP2)) ||
                ((cur.seq_len == SEQ_LEN3) && (acc_shift < MIN_CP3)) ||
                ((cur.seq_len == SEQ_LEN4) && (acc_shift < MIN_CP4)) ||
                (acc_shift > MAX_CP) ||
                ((acc_shift >= SURR_LOW) && (acc_shift <= SURR_HIGH));

    nxt.count = (cur.count < count_cap) ? cur.count + 17'd1 : count_cap;
    if (byte_in == 8'h00) begin
      nxt.null_seen = 1'b1;
    end

    if (!cur.bad) begin
      if (cur.pend == 2'd0) begin
        if (byte_in <= ASCII_MAX) begin
          nxt.seq_len = SEQ_LEN1;
          nxt.acc     = {13'd0, byte_in};
        end else if ((byte_in & LEAD2_MASK) == LEAD2_TAG) begin
          nxt.seq_len = SEQ_LEN2;
          nxt.pend    = 2'd1;
          nxt.acc     = {16'd0, byte_in[4:0]};
        end else if ((byte_in & LEAD3_MASK) == LEAD3_TAG) begin
          nxt.seq_len = SEQ_LEN3;
          nxt.pend    = 2'd2;
          nxt.acc     = {17'd0, byte_in[3:0]};
        end else if ((byte_in & LEAD4_MASK) == LEAD4_TAG) begin
          nxt.seq_len = SEQ_LEN4;
          nxt.pend    = 2'd3;
          nxt.acc     = {18'd0, byte_in[2:0]};
        end else begin
          nxt.bad = 1'b1;
        end
      end else if ((byte_in & CONT_MASK) != CONT_TAG) begin
        nxt.bad = 1'b1;
      end else begin
        nxt.acc  = acc_shift;
        nxt.pend = pend_dec;
        if ((pend_dec == 2'd0) && cp_reject) begin
          nxt.bad = 1'b1;
        end
      end
    end

    fin_bad = nxt.bad || (nxt.pend != 2'd0);

    if (nxt.count > {1'b0, limit}) begin
      res.verdict = VERDICT_TOO_LONG;
    end else if (nxt.null_seen) begin
      res.verdict = VERDICT_NULL;
    end else if (fin_bad) begin
      res.verdict = VERDICT_BAD_UTF8;
    end else begin
      res.verdict = VERDICT_VALID;
    end

    res.length     = nxt.count;
    res.state_next = last_byte ? '0 : nxt;
  end

endmodule

FILE: hdl/utf8sv_regs.sv
module utf8sv_regs
  import utf8sv_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [CFG_W-1:0]   max_bytes
);

  logic sel_max;

  assign pready  = 1'b1;
  assign sel_max = (paddr[PADDR_W-1:2] == REG_MAX_BYTES);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= MAX_BYTES_RESET;
    end else if (psel && penable && pwrite && pready && sel_max) begin
      max_bytes <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_max) begin
      prdata = {{(PDATA_W-CFG_W){1'b0}}, max_bytes};
    end
  end

endmodule

FILE: hdl/utf8_string_validator.sv
// The verdict word is registered: the final byte passes the input stage register, then the result register.
// Throughput: one byte per cycle while byte_stall is low; the per-byte decode sits between the input
// stage register and the result register.
// Reset (synchronous, active high) clears the string state and both stages,
// and sets max_bytes to 65535.
module utf8_string_validator
  import utf8sv_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  logic [7:0]         byte_in,
  input  logic               last_byte,
  output logic               verdict_valid,
  input  logic               verdict_stall,
  output logic [1:0]         verdict,
  output logic [COUNT_W-1:0] length_seen
);

  localparam int unsigned LIMIT_W = (LENGTH_BITS < CFG_W) ? LENGTH_BITS : CFG_W;
  localparam logic [CFG_W-1:0] LIMIT_MASK =
    (LIMIT_W >= CFG_W) ? {CFG_W{1'b1}} : CFG_W'((32'd1 << LIMIT_W) - 32'd1);

  logic [CFG_W-1:0] max_bytes;
  logic [CFG_W-1:0] limit;
  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             s1_last;
  logic             s1_adv;
  str_state_t       st;
  dec_result_t      dec;

  utf8sv_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .max_bytes (max_bytes)
  );

  assign limit = max_bytes & LIMIT_MASK;

  utf8sv_decode u_decode (
    .cur       (st),
    .byte_in   (s1_byte),
    .last_byte (s1_last),
    .limit     (limit),
    .res       (dec)
  );

  // hold the stage only when a final byte meets a stalled result
  assign byte_stall = s1_valid && s1_last && verdict_valid && verdict_stall;
  assign s1_adv     = s1_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!byte_stall) begin
      s1_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      s1_byte <= byte_in;
      s1_last <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (s1_adv) begin
      st <= dec.state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      verdict_valid <= 1'b1;
    end else if (!verdict_stall) begin
      verdict_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last) begin
      verdict     <= dec.verdict;
      length_seen <= dec.length;
    end
  end

`ifndef SYNTHESIS
  a_stall_only_on_last: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> (s1_valid && s1_last && verdict_valid))
    else $error("input stalled without a waiting final byte");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_last) |=> (st == '0))
    else $error("string state not cleared after verdict");

  a_too_long_length: assert property (@(posedge clk) disable iff (rst)
    (verdict_valid && (verdict == VERDICT_TOO_LONG)) |->
      (length_seen == ({1'b0, limit} + 17'd1)))
    else $error("too long verdict without saturated length");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (st.count <= ({1'b0, limit} + 17'd1)))
    else $error("byte count beyond saturation point");
`endif

endmodule
